[rtl/dcp_pkg.sv]
package dcp_pkg;

    localparam int DEF_BUFFER_DEPTH = 32;
    localparam int LEN_W            = 6;

    // item kinds on the input channel
    localparam logic [1:0] KIND_DCS   = 2'd0;
    localparam logic [1:0] KIND_GEN   = 2'd1;
    localparam logic [1:0] KIND_PARAM = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // pending command mode
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_DCS  = 2'd1;
    localparam logic [1:0] MODE_GEN  = 2'd2;

    // dsi data types
    localparam logic [7:0] DT_DCS_SHORT0 = 8'h05;
    localparam logic [7:0] DT_DCS_SHORT1 = 8'h15;
    localparam logic [7:0] DT_DCS_LONG   = 8'h39;
    localparam logic [7:0] DT_GEN_SHORT1 = 8'h13;
    localparam logic [7:0] DT_GEN_SHORT2 = 8'h23;
    localparam logic [7:0] DT_GEN_LONG   = 8'h29;

    typedef struct packed {
        logic             bank;
        logic [7:0]       dtype;
        logic [LEN_W-1:0] len;
        logic [15:0]      wait_ms;
        logic             ovf;
    } t_job;

    function automatic logic [7:0] pick_type(input logic [1:0] mode,
                                             input logic [LEN_W-1:0] count);
        logic dcs;
        dcs = (mode == MODE_DCS);
        if (count == LEN_W'(1)) begin
            pick_type = dcs ? DT_DCS_SHORT0 : DT_GEN_SHORT1;
        end else if (count == LEN_W'(2)) begin
            pick_type = dcs ? DT_DCS_SHORT1 : DT_GEN_SHORT2;
        end else begin
            pick_type = dcs ? DT_DCS_LONG : DT_GEN_LONG;
        end
    endfunction

endpackage

[rtl/dcp_ram.sv]
module dcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/dcp_front.sv]
module dcp_front #(
    parameter int BUFFER_DEPTH = dcp_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [7:0]                      i_data_byte,
    input  logic [15:0]                     i_delay_ms,
    input  logic                            i_busy,
    output logic                            o_push,
    output dcp_pkg::t_job                   o_job,
    output logic                            o_wr_en,
    output logic [$clog2(BUFFER_DEPTH):0]   o_wr_addr,
    output logic [7:0]                      o_wr_data
);
    import dcp_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    logic [LEN_W-1:0] r_count, n_count;
    logic [1:0]       r_mode, n_mode;
    logic [15:0]      r_delay, n_delay;
    logic             r_drop, n_drop;
    logic             r_bank, n_bank;

    logic             needs_flush;
    logic             accept;
    logic [LEN_W-1:0] base_count;
    logic             room;

    assign needs_flush = (r_mode != MODE_NONE) && (i_cmd != KIND_PARAM);
    assign o_in_stall  = needs_flush && i_busy;
    assign accept      = i_in_valid && !o_in_stall;

    assign base_count = needs_flush ? '0 : r_count;
    assign room       = base_count < LEN_W'(BUFFER_DEPTH);

    assign o_push        = accept && needs_flush;
    assign o_job.bank    = r_bank;
    assign o_job.dtype   = pick_type(r_mode, r_count);
    assign o_job.len     = r_count;
    assign o_job.wait_ms = r_delay;
    assign o_job.ovf     = r_drop;

    assign o_wr_en   = accept && (i_cmd != KIND_END) && room;
    assign o_wr_addr = {n_bank, base_count[IDX_W-1:0]};
    assign o_wr_data = i_data_byte;

    always_comb begin
        n_bank  = needs_flush ? ~r_bank : r_bank;
        n_count = base_count;
        n_mode  = needs_flush ? MODE_NONE : r_mode;
        n_drop  = needs_flush ? 1'b0 : r_drop;
        n_delay = r_delay;
        unique case (i_cmd) inside
            KIND_DCS, KIND_GEN: begin
                n_mode  = (i_cmd == KIND_DCS) ? MODE_DCS : MODE_GEN;
                n_delay = i_delay_ms;
                if (room) begin
                    n_count = base_count + LEN_W'(1);
                end else begin
                    n_drop = 1'b1;
                end
            end
            KIND_PARAM: begin
                if (room) begin
                    n_count = base_count + LEN_W'(1);
                end else begin
                    n_drop = 1'b1;
                end
            end
            default: begin
                n_count = '0;
                n_mode  = MODE_NONE;
                n_drop  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= MODE_NONE;
            r_delay <= '0;
            r_drop  <= 1'b0;
            r_bank  <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_mode  <= n_mode;
            r_delay <= n_delay;
            r_drop  <= n_drop;
            r_bank  <= n_bank;
        end
    end

endmodule

[rtl/dcp_job_q.sv]
module dcp_job_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcp_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output dcp_pkg::t_job o_job
);
    import dcp_pkg::*;

    logic r_valid;
    t_job r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_push || (r_valid && !i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job <= i_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

[rtl/dcp_back.sv]
module dcp_back #(
    parameter int BUFFER_DEPTH = dcp_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  dcp_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_busy,
    output logic [$clog2(BUFFER_DEPTH):0] o_rd_addr,
    input  logic [7:0]                    i_rd_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_is_header,
    output logic [7:0]                    o_data_type,
    output logic [dcp_pkg::LEN_W-1:0]     o_length,
    output logic [15:0]                   o_wait_ms,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_overflow,
    output logic                          o_last
);
    import dcp_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_BYTE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_idx, n_idx;
    t_job             r_job;
    logic             r_out_valid, n_out_valid;
    logic             r_is_header, r_last, n_last;
    logic [7:0]       r_payload;
    logic             load_hdr, load_byte, can_load;
    logic [LEN_W-1:0] idx_inc;

    assign can_load = !r_out_valid || !i_out_stall;
    assign idx_inc  = r_idx + LEN_W'(1);
    assign o_busy   = (r_state != ST_IDLE);
    // a new job only once the last result of the previous packet has left
    assign o_pop    = (r_state == ST_IDLE) && i_job_valid && can_load;

    // address runs one step ahead so the read data lines up with r_idx
    assign o_rd_addr = {r_job.bank, n_idx[IDX_W-1:0]};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_last      = r_last;
        load_hdr    = 1'b0;
        load_byte   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (o_pop) begin
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                n_idx = '0;
                if (can_load) begin
                    load_hdr    = 1'b1;
                    n_out_valid = 1'b1;
                    n_last      = (r_job.len == '0);
                    n_state     = (r_job.len == '0) ? ST_IDLE : ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (can_load) begin
                    load_byte   = 1'b1;
                    n_out_valid = 1'b1;
                    n_idx       = idx_inc;
                    n_last      = (idx_inc == r_job.len);
                    if (idx_inc == r_job.len) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load_hdr || load_byte) begin
            r_is_header <= load_hdr;
            r_last      <= n_last;
            r_payload   <= load_hdr ? 8'd0 : i_rd_data;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_header    = r_is_header;
    assign o_data_type    = r_job.dtype;
    assign o_length       = r_job.len;
    assign o_wait_ms      = r_job.wait_ms;
    assign o_payload_byte = r_payload;
    assign o_overflow     = r_job.ovf;
    assign o_last         = r_last;

endmodule

[rtl/dsi_command_packetizer.sv]
// dsi command packetiser
// input channel: i_in_valid / o_in_stall carries one init item (kind, byte, delay).
// command and parameter bytes go into one of two buffer banks; a dcs or generic
// command stays pending until a non-parameter item arrives, which closes the packet.
// output channel: o_out_valid / i_out_stall carries one header result followed by
// one result per buffered byte, the final one flagged with o_last.
// throughput: an item that only collects a byte is taken every cycle; an item that
// closes a packet is held (o_in_stall) while the job queue holds a job or the back
// end is still sending the previous packet, whose bytes are limited by the single
// read port of the byte buffer (one byte per cycle while the output is not stalled).
// header: the closing item's job passes the job queue register and the ST_HDR state.
// reset (synchronous, active low) clears the pending command, counts, queue and
// output valid; buffer contents are not cleared and need not be.
// a receiver stall holds the output register; bytes keep being collected meanwhile.
module dsi_command_packetizer #(
    parameter int BUFFER_DEPTH = dcp_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_cmd,
    input  logic [7:0]                i_data_byte,
    input  logic [15:0]               i_delay_ms,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_is_header,
    output logic [7:0]                o_data_type,
    output logic [dcp_pkg::LEN_W-1:0] o_length,
    output logic [15:0]               o_wait_ms,
    output logic [7:0]                o_payload_byte,
    output logic                      o_overflow,
    output logic                      o_last
);
    import dcp_pkg::*;

    // two banks of the byte buffer, bank select on the top address bit
    localparam int ADDR_W = $clog2(BUFFER_DEPTH) + 1;

    logic              push;
    t_job              push_job;
    logic              q_valid;
    t_job              q_job;
    logic              pop;
    logic              back_busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // front end: decodes items, keeps pending command, fills the buffer
    dcp_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_delay_ms  (i_delay_ms),
        .i_busy      (q_valid || back_busy),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // one-entry packet job queue between front and back
    dcp_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    dcp_ram #(
        .WIDTH (8),
        .DEPTH (2 ** ADDR_W)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // back end: sends header then payload bytes of the closed bank
    dcp_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_header    (o_is_header),
        .o_data_type    (o_data_type),
        .o_length       (o_length),
        .o_wait_ms      (o_wait_ms),
        .o_payload_byte (o_payload_byte),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

endmodule
